/* design/arm_shifter_and_flag_alu_assert.svh */
// Assertion macros used by the top-level design file.
`ifndef ARM_SHIFTER_AND_FLAG_ALU_ASSERT_SVH
`define ARM_SHIFTER_AND_FLAG_ALU_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("asf same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("asf next-cycle check failed");

`endif

/* design/asf_pkg.sv */
package asf_pkg;

    localparam logic [2:0] MODE_LSL = 3'd0;
    localparam logic [2:0] MODE_LSR = 3'd1;
    localparam logic [2:0] MODE_ASR = 3'd2;
    localparam logic [2:0] MODE_ROR = 3'd3;
    localparam logic [2:0] MODE_RRX = 3'd4;
    localparam logic [2:0] MODE_ADD = 3'd5;
    localparam logic [2:0] MODE_SUB = 3'd6;
    localparam logic [2:0] MODE_LOG = 3'd7;

    localparam int unsigned DATA_W = 32;
    localparam logic [7:0]  AMT_WORD = 8'd32;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              negative;
        logic              zero;
        logic              carry_out;
        logic              overflow;
        logic              nzc_written;
        logic              v_written;
    } t_asf_result;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              carry;
    } t_asf_shift;

endpackage

/* design/asf_shifter.sv */
module asf_shifter
    import asf_pkg::*;
(
    input  logic [2:0]        i_mode,
    input  logic [DATA_W-1:0] i_value,
    input  logic [7:0]        i_amount,
    input  logic              i_carry_in,
    output t_asf_shift        o_shift
);

    logic [4:0]          w_amt5;
    logic [DATA_W:0]     w_lsl;
    logic [DATA_W:0]     w_lsr;
    logic [DATA_W:0]     w_asr;
    logic [2*DATA_W-1:0] w_ror;
    logic                w_big;

    assign w_amt5 = i_amount[4:0];
    assign w_big  = (i_amount >= AMT_WORD);
    // 33-bit shifts keep the last bit shifted out next to the result
    assign w_lsl  = {1'b0, i_value} << w_amt5;
    assign w_lsr  = {i_value, 1'b0} >> w_amt5;
    assign w_asr  = $signed({i_value, 1'b0}) >>> w_amt5;
    assign w_ror  = {i_value, i_value} >> w_amt5;

    always_comb begin
        o_shift.result = i_value;
        o_shift.carry  = i_carry_in;
        if (i_mode == MODE_RRX) begin
            o_shift.result = {i_carry_in, i_value[DATA_W-1:1]};
            o_shift.carry  = i_value[0];
        end else if (i_amount != 8'd0) begin
            unique case (i_mode)
                MODE_LSL: begin
                    if (!w_big) begin
                        o_shift.result = w_lsl[DATA_W-1:0];
                        o_shift.carry  = w_lsl[DATA_W];
                    end else begin
                        o_shift.result = '0;
                        o_shift.carry  = (i_amount == AMT_WORD) ? i_value[0] : 1'b0;
                    end
                end
                MODE_LSR: begin
                    if (!w_big) begin
                        o_shift.result = w_lsr[DATA_W:1];
                        o_shift.carry  = w_lsr[0];
                    end else begin
                        o_shift.result = '0;
                        o_shift.carry  = (i_amount == AMT_WORD) ? i_value[DATA_W-1] : 1'b0;
                    end
                end
                MODE_ASR: begin
                    if (!w_big) begin
                        o_shift.result = w_asr[DATA_W:1];
                        o_shift.carry  = w_asr[0];
                    end else begin
                        o_shift.result = {DATA_W{i_value[DATA_W-1]}};
                        o_shift.carry  = i_value[DATA_W-1];
                    end
                end
                default: begin
                    // rotate by the amount mod 32; carry is the new top bit
                    o_shift.result = w_ror[DATA_W-1:0];
                    o_shift.carry  = w_ror[DATA_W-1];
                end
            endcase
        end
    end

endmodule

/* design/asf_alu.sv */
module asf_alu
    import asf_pkg::*;
(
    input  logic [2:0]        i_mode,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    input  logic              i_carry_in,
    input  logic              i_update_flags,
    input  t_asf_shift        i_shift,
    output t_asf_result       o_res
);

    logic [DATA_W-1:0] w_bb;
    logic [DATA_W:0]   w_sum;

    assign w_bb  = (i_mode == MODE_SUB) ? ~i_operand_b : i_operand_b;
    assign w_sum = {1'b0, i_operand_a} + {1'b0, w_bb} + {{DATA_W{1'b0}}, i_carry_in};

    always_comb begin
        o_res = '0;
        unique case (i_mode)
            MODE_ADD, MODE_SUB: begin
                o_res.result = w_sum[DATA_W-1:0];
                if (i_update_flags) begin
                    o_res.nzc_written = 1'b1;
                    o_res.v_written   = 1'b1;
                    o_res.negative    = w_sum[DATA_W-1];
                    o_res.zero        = (w_sum[DATA_W-1:0] == '0);
                    o_res.carry_out   = w_sum[DATA_W];
                    o_res.overflow    = ~(i_operand_a[DATA_W-1] ^ w_bb[DATA_W-1])
                                      & (i_operand_a[DATA_W-1] ^ w_sum[DATA_W-1]);
                end
            end
            MODE_LOG: begin
                o_res.result = i_operand_a;
                if (i_update_flags) begin
                    o_res.nzc_written = 1'b1;
                    o_res.negative    = i_operand_a[DATA_W-1];
                    o_res.zero        = (i_operand_a == '0);
                    o_res.carry_out   = i_carry_in;
                end
            end
            default: begin
                o_res.result    = i_shift.result;
                o_res.carry_out = i_shift.carry;
            end
        endcase
    end

endmodule

/* design/arm_shifter_and_flag_alu.sv */
// Channel   Handshake            Payload
// input     i_valid / o_stall    i_mode i_operand_a i_operand_b i_shift_amount
//                                i_carry_in i_update_flags
// output    o_valid / i_stall    o_result o_negative o_zero o_carry_out
//                                o_overflow o_nzc_written o_v_written
//
// One transaction per cycle while i_stall is low; each passes from the input
// register to the result register, with the shifter and adder between them.
// Synchronous active-low reset clears both valid bits only.
// A stall on the output holds the result register and backs up into the input
// register; o_stall rises only when both registers are full.
`include "arm_shifter_and_flag_alu_assert.svh"

module arm_shifter_and_flag_alu
    import asf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_mode,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    input  logic [7:0]        i_shift_amount,
    input  logic              i_carry_in,
    input  logic              i_update_flags,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_result,
    output logic              o_negative,
    output logic              o_zero,
    output logic              o_carry_out,
    output logic              o_overflow,
    output logic              o_nzc_written,
    output logic              o_v_written
);

    logic              r_in_valid;
    logic [2:0]        r_mode;
    logic [DATA_W-1:0] r_operand_a;
    logic [DATA_W-1:0] r_operand_b;
    logic [7:0]        r_shift_amount;
    logic              r_carry_in;
    logic              r_update_flags;
    logic              r_out_valid;
    t_asf_result       r_out;

    logic              w_out_block;
    logic              w_in_move;
    logic              w_in_acc;
    t_asf_shift        w_shift;
    t_asf_result       w_res;

    assign w_out_block = r_out_valid && i_stall;
    assign w_in_move   = r_in_valid && !w_out_block;
    assign o_stall     = r_in_valid && w_out_block;
    assign w_in_acc    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_in_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode         <= i_mode;
            r_operand_a    <= i_operand_a;
            r_operand_b    <= i_operand_b;
            r_shift_amount <= i_shift_amount;
            r_carry_in     <= i_carry_in;
            r_update_flags <= i_update_flags;
        end
    end

    asf_shifter u_shifter (
        .i_mode     (r_mode),
        .i_value    (r_operand_a),
        .i_amount   (r_shift_amount),
        .i_carry_in (r_carry_in),
        .o_shift    (w_shift)
    );

    asf_alu u_alu (
        .i_mode         (r_mode),
        .i_operand_a    (r_operand_a),
        .i_operand_b    (r_operand_b),
        .i_carry_in     (r_carry_in),
        .i_update_flags (r_update_flags),
        .i_shift        (w_shift),
        .o_res          (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            // drop the result once taken
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_move) begin
            r_out <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result      = r_out.result;
    assign o_negative    = r_out.negative;
    assign o_zero        = r_out.zero;
    assign o_carry_out   = r_out.carry_out;
    assign o_overflow    = r_out.overflow;
    assign o_nzc_written = r_out.nzc_written;
    assign o_v_written   = r_out.v_written;

    `ASF_ASSERT_IMP(a_v_needs_nzc, i_clk, i_rst_n, o_valid && o_v_written, o_nzc_written)
    `ASF_ASSERT_IMP(a_no_flags_clear, i_clk, i_rst_n, o_valid && !o_nzc_written,
                    !o_negative && !o_zero && !o_overflow)
    `ASF_ASSERT_NXT(a_move_fills_out, i_clk, i_rst_n, w_in_move, r_out_valid)
    `ASF_ASSERT_IMP(a_stall_when_full, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid)

endmodule
